// ----- hw/rtl/adt_pkg.sv -----
// Advertiser dedup table: shared types and constants.
// Used by advertiser_dedup_table. No dependencies.
`timescale 1ns / 1ps

package adt_pkg;

    localparam int SLOT_W = 4;
    localparam int COUNT_W = 4;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // event types that mark an advertiser as connectable
    localparam logic [2:0] ADV_CONN_IND        = 3'd0;
    localparam logic [2:0] ADV_CONN_DIRECT_IND = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_REPORT,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [47:0] address;
        logic [1:0]  addr_kind;
        logic [2:0]  adv_kind;
        logic        connectable;
        logic [7:0]  signal;
    } t_entry;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              inserted;
        logic              dropped;
        logic [COUNT_W-1:0] count_now;
        t_entry            got;
    } t_result;

endpackage

// ----- hw/rtl/adt_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module adt_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 12
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/advertiser_dedup_table.sv -----
// Advertiser dedup table top level: sequencer, single comparator, result register.
// Depends on adt_pkg and adt_ram.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; its result appears on the
// o_ ports for one cycle with o_result_valid, and cannot be held off. Entries sit
// in one RAM with a registered read port, and a single key comparator walks them
// one per cycle. Record and find stop at the first hit or after the last entry;
// read fetches one entry if the index is below the count and otherwise reports
// not found; clear empties the table. The result strobe follows in the cycle
// after the last busy cycle, during which busy is already low and a new item may
// be taken.

module advertiser_dedup_table #(
    parameter int MAX_ENTRIES = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_op,
    input  logic [1:0]         i_addr_kind,
    input  logic [2:0]         i_adv_kind,
    input  logic [47:0]        i_peer_address,
    input  logic signed [7:0]  i_signal_strength,
    input  logic [3:0]         i_slot_index,
    output logic               o_result_valid,
    output logic               o_found,
    output logic [3:0]         o_slot,
    output logic               o_inserted,
    output logic               o_dropped,
    output logic [3:0]         o_count_now,
    output logic [1:0]         o_got_addr_kind,
    output logic [2:0]         o_got_adv_kind,
    output logic               o_got_connectable,
    output logic [47:0]        o_got_address,
    output logic signed [7:0]  o_got_signal
);

    import adt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
    localparam int ENTRY_W = $bits(t_entry);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    t_result            r_res, n_res;
    logic               r_res_valid, n_res_valid;

    logic [1:0]         r_op;
    logic [1:0]         r_kind;
    logic [2:0]         r_adv;
    logic [47:0]        r_addr;
    logic [7:0]         r_sig;
    logic [3:0]         r_slot_in;

    logic               accept;
    logic               hit;
    logic               more;
    logic               conn_new;
    logic               full;
    logic               idx_ok;
    t_entry             rd;
    t_entry             wr_entry;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    adt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd       = t_entry'(ram_rdata);
    assign hit      = (r_state == ST_SCAN) && r_pend
                      && (rd.addr_kind == r_kind) && (rd.address == r_addr);
    assign more     = (r_ptr < r_count);
    assign conn_new = (r_adv == ADV_CONN_IND) || (r_adv == ADV_CONN_DIRECT_IND);
    assign full     = (r_count >= MAX_CNT);
    assign idx_ok   = (CMP_W'(r_slot_in) < CMP_W'(r_count));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_READ:  n_state = ST_FETCH;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit || (!more && !r_pend)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FETCH:  n_state = idx_ok ? ST_REPORT : ST_IDLE;
            ST_REPORT: n_state = ST_IDLE;
            ST_CLEAR:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_res       = r_res;
        n_res_valid = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_pend_idx;
        ram_re      = 1'b0;
        ram_raddr   = r_ptr[IDX_W-1:0];
        wr_entry.address     = r_addr;
        wr_entry.addr_kind   = r_kind;
        wr_entry.adv_kind    = r_adv;
        wr_entry.connectable = conn_new;
        wr_entry.signal      = r_sig;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_ptr  = '0;
                    n_pend = 1'b0;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                    n_res.found = 1'b1;
                    n_res.slot  = SLOT_W'(r_pend_idx);
                    if (r_op == OP_RECORD) begin
                        wr_entry.connectable = rd.connectable | conn_new;
                        ram_we    = 1'b1;
                        ram_waddr = r_pend_idx;
                        n_res.got = wr_entry;
                    end else begin
                        n_res.got = rd;
                    end
                end else if (more) begin
                    ram_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr[IDX_W-1:0];
                    n_ptr      = r_ptr + CNT_W'(1);
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                    if (r_op == OP_RECORD) begin
                        if (full) begin
                            n_res.dropped = 1'b1;
                        end else begin
                            ram_we         = 1'b1;
                            ram_waddr      = r_count[IDX_W-1:0];
                            n_count        = r_count + CNT_W'(1);
                            n_res.inserted = 1'b1;
                            n_res.slot     = SLOT_W'(r_count);
                            n_res.got      = wr_entry;
                        end
                    end
                end
            end
            ST_FETCH: begin
                if (idx_ok) begin
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(r_slot_in);
                end else begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                end
            end
            ST_REPORT: begin
                n_res_valid = 1'b1;
                n_res       = '0;
                n_res.found = 1'b1;
                n_res.slot  = r_slot_in;
                n_res.got   = rd;
            end
            ST_CLEAR: begin
                n_count     = '0;
                n_res_valid = 1'b1;
                n_res       = '0;
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase

        if (n_res_valid) begin
            n_res.count_now = COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_res      <= n_res;
        if (accept) begin
            r_op      <= i_op;
            r_kind    <= i_addr_kind;
            r_adv     <= i_adv_kind;
            r_addr    <= i_peer_address;
            r_sig     <= i_signal_strength;
            r_slot_in <= i_slot_index;
        end
    end

    assign o_result_valid    = r_res_valid;
    assign o_found           = r_res.found;
    assign o_slot            = r_res.slot;
    assign o_inserted        = r_res.inserted;
    assign o_dropped         = r_res.dropped;
    assign o_count_now       = r_res.count_now;
    assign o_got_addr_kind   = r_res.got.addr_kind;
    assign o_got_adv_kind    = r_res.got.adv_kind;
    assign o_got_connectable = r_res.got.connectable;
    assign o_got_address     = r_res.got.address;
    assign o_got_signal      = $signed(r_res.got.signal);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("entry count beyond table size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("item taken but block not busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without an item in progress");

    a_write_on_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_SCAN) && (r_op == OP_RECORD)))
        else $error("table written outside a record");

endmodule

// ----- tb/testbench.sv -----
// Testbench for advertiser_dedup_table: directed table then random record, find, read, clear.
// Results are checked against an in-bench model of the advertiser table.
// Depends on adt_pkg and the advertiser_dedup_table RTL.
`timescale 1ns / 1ps

module testbench;
    import adt_pkg::*;

    localparam int TABLE_DEPTH  = 12;
    localparam int RANDOM_ITEMS = 400;
    localparam int KEY_POOL     = 20;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [2:0]  adv;
        logic [47:0] addr;
        logic [7:0]  sig;
        logic [3:0]  idx;
        logic        typed;
        logic [3:0]  exp_count;
        logic        exp_drop;
    } t_stim;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_op;
    logic [1:0]         i_addr_kind;
    logic [2:0]         i_adv_kind;
    logic [47:0]        i_peer_address;
    logic signed [7:0]  i_signal_strength;
    logic [3:0]         i_slot_index;
    logic               o_result_valid;
    logic               o_found;
    logic [3:0]         o_slot;
    logic               o_inserted;
    logic               o_dropped;
    logic [3:0]         o_count_now;
    logic [1:0]         o_got_addr_kind;
    logic [2:0]         o_got_adv_kind;
    logic               o_got_connectable;
    logic [47:0]        o_got_address;
    logic signed [7:0]  o_got_signal;

    advertiser_dedup_table #(.MAX_ENTRIES(TABLE_DEPTH)) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_addr_kind       (i_addr_kind),
        .i_adv_kind        (i_adv_kind),
        .i_peer_address    (i_peer_address),
        .i_signal_strength (i_signal_strength),
        .i_slot_index      (i_slot_index),
        .o_result_valid    (o_result_valid),
        .o_found           (o_found),
        .o_slot            (o_slot),
        .o_inserted        (o_inserted),
        .o_dropped         (o_dropped),
        .o_count_now       (o_count_now),
        .o_got_addr_kind   (o_got_addr_kind),
        .o_got_adv_kind    (o_got_adv_kind),
        .o_got_connectable (o_got_connectable),
        .o_got_address     (o_got_address),
        .o_got_signal      (o_got_signal)
    );

    // model of the table
    t_entry     adv_table [TABLE_DEPTH];
    int         adv_count;
    t_result    pending_results [$];
    t_stim      directed_rows [$];
    t_stim      cur_item;
    logic [49:0] key_pool [KEY_POOL];

    int mismatches;
    int quiet_cycles;
    int items_taken;
    int n_inserts, n_refreshes, n_drops, n_find_hits, n_read_hits, n_clears;
    bit idling_on;

    initial i_clk = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("MISMATCH item %0d field %s: got 0x%0h, expected 0x%0h",
                 items_taken, field, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string field, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // apply one item to the model table and form its result
    task automatic update_table(input t_stim s, output t_result r);
        int   hit;
        int   slot_i;
        logic conn;
        r = '0;
        hit = -1;
        slot_i = -1;
        if (s.op == OP_RECORD || s.op == OP_FIND) begin
            for (int i = 0; i < adv_count; i++) begin
                if (hit < 0 && adv_table[i].addr_kind == s.kind && adv_table[i].address == s.addr)
                    hit = i;
            end
        end
        case (s.op)
            OP_RECORD: begin
                conn = (s.adv == ADV_CONN_IND || s.adv == ADV_CONN_DIRECT_IND);
                if (hit >= 0) begin
                    r.found = 1'b1;
                    slot_i = hit;
                    adv_table[slot_i].connectable = adv_table[slot_i].connectable | conn;
                    n_refreshes++;
                end else if (adv_count >= TABLE_DEPTH) begin
                    r.dropped = 1'b1;
                    n_drops++;
                end else begin
                    slot_i = adv_count;
                    adv_count++;
                    r.inserted = 1'b1;
                    adv_table[slot_i].connectable = conn;
                    n_inserts++;
                end
                if (slot_i >= 0) begin
                    adv_table[slot_i].addr_kind = s.kind;
                    adv_table[slot_i].adv_kind  = s.adv;
                    adv_table[slot_i].address   = s.addr;
                    adv_table[slot_i].signal    = s.sig;
                    r.slot = slot_i[3:0];
                    r.got  = adv_table[slot_i];
                end
            end
            OP_FIND: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot  = hit[3:0];
                    r.got   = adv_table[hit];
                    n_find_hits++;
                end
            end
            OP_READ: begin
                if (int'(s.idx) < adv_count) begin
                    r.found = 1'b1;
                    r.slot  = s.idx;
                    r.got   = adv_table[s.idx];
                    n_read_hits++;
                end
            end
            default: begin
                adv_count = 0;
                n_clears++;
            end
        endcase
        r.count_now = adv_count[3:0];
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result predicted;
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 48'd0, 48'd0);
                end else begin
                    want = pending_results.pop_front();
                    check_field("found", 48'(o_found), 48'(want.found));
                    check_field("slot", 48'(o_slot), 48'(want.slot));
                    check_field("inserted", 48'(o_inserted), 48'(want.inserted));
                    check_field("dropped", 48'(o_dropped), 48'(want.dropped));
                    check_field("count_now", 48'(o_count_now), 48'(want.count_now));
                    check_field("got_addr_kind", 48'(o_got_addr_kind),
                                48'(want.got.addr_kind));
                    check_field("got_adv_kind", 48'(o_got_adv_kind),
                                48'(want.got.adv_kind));
                    check_field("got_connectable", 48'(o_got_connectable),
                                48'(want.got.connectable));
                    check_field("got_address", o_got_address, want.got.address);
                    check_field("got_signal", 48'($unsigned(o_got_signal)),
                                48'(want.got.signal));
                end
            end
            if (start && !busy) begin
                update_table(cur_item, predicted);
                if (cur_item.typed) begin
                    want = '0;
                    want.count_now = cur_item.exp_count;
                    want.dropped   = cur_item.exp_drop;
                    pending_results.push_back(want);
                end else begin
                    pending_results.push_back(predicted);
                end
                items_taken++;
            end
            if (o_result_valid || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("stalled: nothing taken or returned for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic add_row(input logic [1:0] op, input logic [1:0] kind, input logic [2:0] adv,
                           input logic [47:0] addr, input logic [7:0] sig,
                           input logic [3:0] idx, input logic typed,
                           input logic [3:0] exp_count, input logic exp_drop);
        t_stim s;
        s = '{op, kind, adv, addr, sig, idx, typed, exp_count, exp_drop};
        directed_rows.push_back(s);
    endtask

    task automatic drive_noise();
        logic [63:0] r64;
        r64 = {$urandom, $urandom};
        i_op              = r64[1:0];
        i_addr_kind       = r64[3:2];
        i_adv_kind        = r64[6:4];
        i_peer_address    = r64[63:16];
        i_signal_strength = r64[15:8];
        i_slot_index      = r64[11:8];
    endtask

    // present one item, idling first at random, and hold it until taken
    task automatic drive_item(input t_stim s);
        if (idling_on && $urandom_range(99) < 26) begin
            repeat ($urandom_range(3, 1)) begin
                start = 1'b0;
                drive_noise();
                @(negedge i_clk);
            end
        end
        cur_item          = s;
        start             = 1'b1;
        i_op              = s.op;
        i_addr_kind       = s.kind;
        i_adv_kind        = s.adv;
        i_peer_address    = s.addr;
        i_signal_strength = s.sig;
        i_slot_index      = s.idx;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    task automatic wait_table_idle();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic t_stim random_item();
        t_stim       s;
        logic [63:0] r64;
        int          pick;
        s = '0;
        r64 = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 2)
            s.op = OP_CLEAR;
        else if (pick < 55)
            s.op = OP_RECORD;
        else if (pick < 75)
            s.op = OP_FIND;
        else
            s.op = OP_READ;
        if ($urandom_range(99) < 80)
            {s.kind, s.addr} = key_pool[$urandom_range(KEY_POOL - 1)];
        else
            {s.kind, s.addr} = r64[49:0];
        s.adv = 3'($urandom_range(7));
        s.sig = 8'($urandom_range(255));
        s.idx = 4'($urandom_range(15));
        return s;
    endfunction

    initial begin
        logic [63:0] r64;
        t_stim       s;
        mismatches   = 0;
        quiet_cycles = 0;
        items_taken  = 0;
        adv_count    = 0;
        idling_on    = 1'b1;
        n_inserts = 0; n_refreshes = 0; n_drops = 0;
        n_find_hits = 0; n_read_hits = 0; n_clears = 0;
        cur_item = '0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        drive_noise();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // op, kind, adv, address, signal, index, typed, count, dropped
        add_row(OP_READ,   2'd0, 3'd0, 48'h0,            8'h00, 4'd0,  1'b1, 4'd0,  1'b0);
        add_row(OP_FIND,   2'd0, 3'd0, 48'h0,            8'h00, 4'd0,  1'b1, 4'd0,  1'b0);
        add_row(OP_RECORD, 2'd0, 3'd0, 48'h0,            8'h80, 4'd0,  1'b0, 4'd0,  1'b0);
        add_row(OP_RECORD, 2'd3, 3'd7, 48'hFFFF_FFFF_FFFF, 8'h7F, 4'd15, 1'b0, 4'd0, 1'b0);
        add_row(OP_RECORD, 2'd2, 3'd2, 48'hFFFF_FFFF_FFFF, 8'h00, 4'd0, 1'b0, 4'd0, 1'b0);
        add_row(OP_RECORD, 2'd0, 3'd5, 48'h0,            8'h05, 4'd0,  1'b0, 4'd0,  1'b0);
        add_row(OP_RECORD, 2'd3, 3'd1, 48'hFFFF_FFFF_FFFF, 8'hFF, 4'd0, 1'b0, 4'd0, 1'b0);
        add_row(OP_FIND,   2'd3, 3'd0, 48'hFFFF_FFFF_FFFF, 8'h00, 4'd0, 1'b0, 4'd0, 1'b0);
        add_row(OP_READ,   2'd0, 3'd0, 48'h0,            8'h00, 4'd2,  1'b0, 4'd0,  1'b0);
        add_row(OP_READ,   2'd0, 3'd0, 48'h0,            8'h00, 4'd15, 1'b1, 4'd3,  1'b0);
        for (int k = 1; k <= 9; k++)
            add_row(OP_RECORD, k[1:0], k[2:0], 48'(k) << (k * 4), 8'(k * 13), 4'd0,
                    1'b0, 4'd0, 1'b0);
        add_row(OP_RECORD, 2'd1, 3'd0, 48'h5A5A_A5A5_0F0F, 8'h10, 4'd0, 1'b1, 4'd12, 1'b1);
        add_row(OP_RECORD, 2'd2, 3'd0, 48'hFFFF_FFFF_FFFF, 8'hC0, 4'd0, 1'b0, 4'd0, 1'b0);
        add_row(OP_READ,   2'd0, 3'd0, 48'h0,            8'h00, 4'd12, 1'b1, 4'd12, 1'b0);
        add_row(OP_CLEAR,  2'd3, 3'd7, 48'hFFFF_FFFF_FFFF, 8'hFF, 4'd15, 1'b1, 4'd0, 1'b0);
        add_row(OP_READ,   2'd0, 3'd0, 48'h0,            8'h00, 4'd0,  1'b1, 4'd0,  1'b0);
        // fresh entry in a previously connectable slot starts unconnectable
        add_row(OP_RECORD, 2'd0, 3'd4, 48'h0,            8'h01, 4'd0,  1'b0, 4'd0,  1'b0);

        foreach (directed_rows[k])
            drive_item(directed_rows[k]);
        wait_table_idle();

        for (int k = 0; k < KEY_POOL; k++) begin
            r64 = {$urandom, $urandom};
            key_pool[k] = r64[49:0];
            if (k > 0 && $urandom_range(3) == 0)
                key_pool[k][47:0] = key_pool[k - 1][47:0];
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            idling_on = !(k >= 150 && k < 250);
            if (k == 300)
                wait_table_idle();
            s = random_item();
            drive_item(s);
        end

        wait_table_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d items: %0d inserts, %0d refreshes, %0d drops on a full table,",
                 items_taken, n_inserts, n_refreshes, n_drops);
        $display("%0d find hits, %0d read hits, %0d clears", n_find_hits, n_read_hits, n_clears);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- advertiser_dedup_table.f -----
hw/rtl/adt_pkg.sv
hw/rtl/adt_ram.sv
hw/rtl/advertiser_dedup_table.sv
tb/testbench.sv
